@@ sv/cjss_pkg.sv @@
// Shared constants, types and reset table for the closest joint solution selector.
`timescale 1ns / 1ps

package cjss_pkg;

  localparam int JOINT_COUNT = 6;
  localparam int WRAP_JOINT  = 3;
  localparam int ANGLE_BITS  = 16;

  // Q3.12 constants
  localparam int FRAC_ONE   = 4096;
  localparam int FIX_PI     = 12868;
  localparam int FIX_TWO_PI = 25736;

  // Squared distance: each square fits 2*ANGLE_BITS, plus growth for the sum
  localparam int SQ_BITS   = 2 * ANGLE_BITS;
  localparam int DIST_BITS = SQ_BITS + $clog2(JOINT_COUNT);

  // Configuration index wide enough to also carry out-of-range indexes
  localparam int CFG_IDX_BITS = $clog2(JOINT_COUNT + 1);

  // Output queue
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);
  // Highest fill level at which a word may still push two results
  localparam int OQ_GO_LIMIT = OQ_DEPTH - 2;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef angle_t [JOINT_COUNT-1:0] pose_t;

  // Wrap window: only negative angles within one radian of -pi change value
  localparam angle_t WRAP_LO  = angle_t'(-(FIX_PI + FRAC_ONE - 1));
  localparam angle_t WRAP_HI  = angle_t'(-(FIX_PI - FRAC_ONE + 1));
  localparam angle_t WRAP_ADD = angle_t'(FIX_TWO_PI);

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_BEST = 1'b1;

  typedef struct packed {
    logic  kind;
    pose_t angles;
    logic  run_last;
  } out_word_t;

  function automatic angle_t start_reset(input int j);
    angle_t r;
    case (j)
      0: r = angle_t'(6544);
      1: r = angle_t'(1209);
      2: r = angle_t'(8833);
      3: r = angle_t'(12704);
      4: r = angle_t'(-2027);
      5: r = angle_t'(-67);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/closest_joint_solution_select.sv @@
// Closest joint solution selector: wraps, echoes and picks the nearest IK candidate.
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Word
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid_i/in_stall_o   | angle_in_0..5, last_candidate
// out     | output    | out_valid_o/out_stall_i | result_kind, angle_out_0..5, run_last
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i (start angles)
//
// One word per cycle while the queue is at two or below. In the input register,
// wrap, six squares, the adder tree and the running-minimum compare are done in one
// pass; a word's results land in a 4-deep output queue (one, or two on the last word).
// in_stall_o is set only from registers: input register full and the queue above two.
// Reset loads the reference pose from the start-angle reset values, clears the best.
// A stalled output holds its word; the input keeps flowing until the queue is above two.

module closest_joint_solution_select (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [cjss_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [cjss_pkg::ANGLE_BITS-1:0]       cfg_data_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_0_i,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_1_i,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_2_i,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_3_i,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_4_i,
  input  logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_in_5_i,
  input  logic                                  last_candidate_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  result_kind_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_0_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_1_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_2_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_3_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_4_o,
  output logic signed [cjss_pkg::ANGLE_BITS-1:0] angle_out_5_o,
  output logic                                  run_last_o
);

  localparam int JC = cjss_pkg::JOINT_COUNT;
  localparam int AB = cjss_pkg::ANGLE_BITS;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  cjss_pkg::pose_t in_pose;
  cjss_pkg::pose_t s1_pose_q;
  logic            s1_last_q;
  logic            s1_valid_q, s1_valid_d;
  logic            in_acc;
  logic            go;

  assign in_pose[0] = angle_in_0_i;
  assign in_pose[1] = angle_in_1_i;
  assign in_pose[2] = angle_in_2_i;
  assign in_pose[3] = angle_in_3_i;
  assign in_pose[4] = angle_in_4_i;
  assign in_pose[5] = angle_in_5_i;

  logic [cjss_pkg::OQ_CNT_BITS-1:0] oq_cnt_q, oq_cnt_d;

  // Room for the worst case (two results) judged on the registered fill level
  assign go         = s1_valid_q && (oq_cnt_q <= cjss_pkg::OQ_CNT_BITS'(cjss_pkg::OQ_GO_LIMIT));
  assign in_stall_o = s1_valid_q && !go;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_acc || (s1_valid_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pose_q <= in_pose;
      s1_last_q <= last_candidate_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Wrap, distance and running minimum
  // ---------------------------------------------------------------------------
  cjss_pkg::pose_t ref_q;
  cjss_pkg::pose_t best_q;
  cjss_pkg::pose_t cand;
  cjss_pkg::pose_t new_best;
  logic [cjss_pkg::DIST_BITS-1:0] best_dist_q;
  logic [cjss_pkg::DIST_BITS-1:0] cand_dist;
  logic                           has_best_q;
  logic                           take;

  // Only wrap-joint angles inside the negative window move, by adding 2pi.
  always_comb begin
    cand = s1_pose_q;
    if (cjss_pkg::WRAP_JOINT < JC) begin
      if ((s1_pose_q[cjss_pkg::WRAP_JOINT] >= cjss_pkg::WRAP_LO) &&
          (s1_pose_q[cjss_pkg::WRAP_JOINT] <= cjss_pkg::WRAP_HI)) begin
        cand[cjss_pkg::WRAP_JOINT] = s1_pose_q[cjss_pkg::WRAP_JOINT] + cjss_pkg::WRAP_ADD;
      end
    end
  end

  always_comb begin
    logic signed [AB:0]              diff;
    logic signed [AB:0]              diff_abs;
    logic [AB-1:0]                   mag;
    logic [cjss_pkg::SQ_BITS-1:0]    sq;
    cand_dist = '0;
    for (int j = 0; j < JC; j++) begin
      diff      = {cand[j][AB-1], cand[j]} - {ref_q[j][AB-1], ref_q[j]};
      diff_abs  = diff[AB] ? -diff : diff;
      mag       = diff_abs[AB-1:0];
      sq        = mag * mag;
      cand_dist = cand_dist + cjss_pkg::DIST_BITS'(sq);
    end
  end

  // First candidate of a set always wins; ties keep the earlier one
  assign take     = !has_best_q || (cand_dist < best_dist_q);
  assign new_best = take ? cand : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < JC; j++) begin
        ref_q[j] <= cjss_pkg::start_reset(j);
      end
      best_q      <= '0;
      best_dist_q <= '1;
      has_best_q  <= 1'b0;
    end else begin
      if (go) begin
        if (s1_last_q) begin
          best_q      <= new_best;
          ref_q       <= new_best;
          best_dist_q <= '1;
          has_best_q  <= 1'b0;
        end else if (take) begin
          best_q      <= cand;
          best_dist_q <= cand_dist;
          has_best_q  <= 1'b1;
        end
      end
      // start-angle write goes straight to the reference; out-of-range index drops
      if (cfg_we_i) begin
        for (int j = 0; j < JC; j++) begin
          if (cfg_idx_i == cjss_pkg::CFG_IDX_BITS'(j)) begin
            ref_q[j] <= cfg_data_i;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------------------
  cjss_pkg::out_word_t              oq_mem [cjss_pkg::OQ_DEPTH];
  cjss_pkg::out_word_t              echo_word, best_word, head;
  logic [cjss_pkg::OQ_PTR_BITS-1:0] oq_wr_q, oq_wr_d, oq_wr_nx, oq_rd_q, oq_rd_d;
  logic [cjss_pkg::OQ_CNT_BITS-1:0] n_push;
  logic                             pop;

  assign echo_word.kind     = cjss_pkg::KIND_ECHO;
  assign echo_word.angles   = cand;
  assign echo_word.run_last = !s1_last_q;
  assign best_word.kind     = cjss_pkg::KIND_BEST;
  assign best_word.angles   = new_best;
  assign best_word.run_last = 1'b1;

  assign head        = oq_mem[oq_rd_q];
  assign out_valid_o = (oq_cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  assign n_push   = !go ? '0 : (s1_last_q ? cjss_pkg::OQ_CNT_BITS'(2) :
                                            cjss_pkg::OQ_CNT_BITS'(1));
  assign oq_wr_nx = oq_wr_q + 1'b1;
  assign oq_wr_d  = oq_wr_q + n_push[cjss_pkg::OQ_PTR_BITS-1:0];
  assign oq_rd_d  = pop ? oq_rd_q + 1'b1 : oq_rd_q;
  assign oq_cnt_d = oq_cnt_q + n_push - cjss_pkg::OQ_CNT_BITS'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_wr_q  <= oq_wr_d;
      oq_rd_q  <= oq_rd_d;
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      oq_mem[oq_wr_q] <= echo_word;
      if (s1_last_q) begin
        oq_mem[oq_wr_nx] <= best_word;
      end
    end
  end

  assign result_kind_o = head.kind;
  assign angle_out_0_o = head.angles[0];
  assign angle_out_1_o = head.angles[1];
  assign angle_out_2_o = head.angles[2];
  assign angle_out_3_o = head.angles[3];
  assign angle_out_4_o = head.angles[4];
  assign angle_out_5_o = head.angles[5];
  assign run_last_o    = head.run_last;

endmodule
